@@ design/ssep_pkg.sv @@
package ssep_pkg;

  // field widths
  localparam int WORD_W      = 16;
  localparam int SETPOINT_W  = 16;
  localparam int POSITION_W  = 15;
  localparam int ERR_W       = 17;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 12;
  localparam int FAULT_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_LIMIT  = 3'd4;

  // register reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET    = 16'd1536;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET   = 16'd512;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET   = 16'd0;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET = 12'd3000;
  localparam logic [FAULT_W-1:0] FAULT_LIMIT_RESET  = 8'd10;

  // encoder decoding
  localparam logic [WORD_W-1:0]            ODD_MASK       = 16'h2AAA;
  localparam logic [WORD_W-1:0]            EVEN_MASK      = 16'h1555;
  localparam int                           POS_FIELD_W    = 14;
  localparam logic [WORD_W-1:0]            POS_SPAN       = 16'd16384;
  localparam logic [WORD_W-1:0]            POS_WRAP       = 16'd12000;
  localparam logic signed [POSITION_W-1:0] POS_HIGH       = 15'sd11500;
  localparam logic signed [POSITION_W-1:0] POS_LOW        = -15'sd10;
  localparam logic signed [POSITION_W-1:0] POSITION_RESET = 15'sd4500;
  localparam logic [FAULT_W-1:0]           FAULT_MAX      = 8'd255;

  // controller
  localparam logic signed [ERR_W-1:0] DEADBAND    = 17'sd3;
  localparam int                      RECIP_W     = 17;
  localparam logic [RECIP_W-1:0]      RECIP_500   = 17'd67109;
  localparam int                      RECIP_SHIFT = 25;
  localparam int                      QUOT_W      = 9;
  localparam logic signed [31:0]      SUM_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]      SUM_MIN     = 32'sh8000_0000;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] output_limit;
    logic [FAULT_W-1:0] fault_limit;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0]            response_word;
    logic signed [SETPOINT_W-1:0] setpoint;
    logic                         auto_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [POSITION_W-1:0] position;
    logic [LIMIT_W-1:0]           drive_magnitude;
    logic                         direction;
    logic                         drive_enable;
    logic                         check_ok;
    logic [FAULT_W-1:0]           fault_count;
  } out_item_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic signed [POSITION_W-1:0] position;
    logic signed [ERR_W-1:0]      err;
    logic                         active;
    logic                         deadband;
    logic                         drive_enable;
    logic                         check_ok;
    logic [FAULT_W-1:0]           fault_count;
  } front_item_t;

endpackage

@@ design/ssep_front.sv @@
module ssep_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ssep_pkg::in_item_t     in_data,
  input  logic [ssep_pkg::FAULT_W-1:0] fault_limit,
  output logic                   push_valid,
  input  logic                   push_ready,
  output ssep_pkg::front_item_t  push_data
);
  import ssep_pkg::*;

  logic signed [POSITION_W-1:0] last_position, last_position_next;
  logic [FAULT_W-1:0]           bad_count, bad_count_next;
  logic                         word_ok;
  logic [WORD_W-1:0]            raw_pos;
  logic signed [POSITION_W-1:0] word_pos;
  logic signed [ERR_W-1:0]      err;
  logic                         in_range;
  logic                         accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // check bits: each is the inverted parity of its half, and an all-zero word fails
  assign word_ok = (in_data.response_word != '0)
                && (in_data.response_word[15] == ~(^(in_data.response_word & ODD_MASK)))
                && (in_data.response_word[14] == ~(^(in_data.response_word & EVEN_MASK)));

  // position from the low field, wrapped into the negative range above the wrap point
  assign raw_pos  = POS_SPAN - {2'b00, in_data.response_word[POS_FIELD_W-1:0]};
  assign word_pos = (raw_pos > POS_WRAP) ? POSITION_W'(raw_pos - POS_SPAN)
                                         : POSITION_W'(raw_pos);

  // tracked position and bad-word count
  always_comb begin
    if (word_ok) begin
      last_position_next = word_pos;
      bad_count_next     = '0;
    end else begin
      last_position_next = last_position;
      bad_count_next     = (bad_count == FAULT_MAX) ? bad_count : bad_count + 1'b1;
    end
  end

  // classification for the controller
  assign in_range = (last_position_next <= POS_HIGH) && (last_position_next >= POS_LOW);
  assign err = $signed({in_data.setpoint[SETPOINT_W-1], in_data.setpoint})
             - $signed({{(ERR_W-POSITION_W){last_position_next[POSITION_W-1]}},
                        last_position_next});

  always_comb begin
    push_data.position     = last_position_next;
    push_data.err          = err;
    push_data.active       = in_range && in_data.auto_mode;
    push_data.deadband     = (err <= DEADBAND) && (err >= -DEADBAND);
    push_data.drive_enable = bad_count_next < fault_limit;
    push_data.check_ok     = word_ok;
    push_data.fault_count  = bad_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position <= POSITION_RESET;
      bad_count     <= '0;
    end else if (accept) begin
      last_position <= last_position_next;
      bad_count     <= bad_count_next;
    end
  end

endmodule

@@ design/ssep_fifo.sv @@
module ssep_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  ssep_pkg::front_item_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output ssep_pkg::front_item_t pop_data
);
  import ssep_pkg::*;

  front_item_t             entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;
  logic                    push;
  logic                    pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_fill_bounded : assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

endmodule

@@ design/ssep_back.sv @@
module ssep_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ssep_pkg::cfg_t        cfg,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  ssep_pkg::front_item_t pop_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ssep_pkg::out_item_t   out_data
);
  import ssep_pkg::*;

  typedef struct packed {
    front_item_t        item;
    logic [ERR_W-1:0]   mag;
    logic [QUOT_W-1:0]  quot;
    logic signed [33:0] prop_prod;
    logic signed [33:0] kd_err;
  } st1_t;

  typedef struct packed {
    front_item_t         item;
    logic signed [QUOT_W:0] t;
    logic                rem_pos;
    logic                rem_neg;
    logic signed [33:0]  prop_prod;
    logic signed [42:0]  deriv_prod;
  } st2_t;

  typedef struct packed {
    front_item_t        item;
    logic signed [31:0] s;
    logic signed [43:0] pd;
  } st3_t;

  typedef struct packed {
    front_item_t        item;
    logic signed [43:0] pd;
    logic signed [48:0] ki_prod;
  } st4_t;

  typedef struct packed {
    front_item_t        item;
    logic signed [49:0] acc;
  } st5_t;

  logic adv;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  st4_t s4, s4_next;
  st5_t s5, s5_next;
  out_item_t out_next;

  logic signed [31:0] integral_sum;

  logic [ERR_W+RECIP_W-1:0] recip_prod;
  logic [QUOT_W+8:0]        quot_x500;
  logic signed [42:0]       kd_ext;
  logic signed [33:0]       i_ext, t_ext, j_mid, j_lo, j_hi, s_raw;
  logic signed [31:0]       s_sat;
  logic signed [49:0]       u_num;
  logic signed [41:0]       u;
  logic signed [41:0]       lim_ext;
  logic signed [LIMIT_W:0]  drive;

  // whole pipe moves together whenever the output register can take a beat
  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;

  // stage 1: divide |err| by 500 through a reciprocal, proportional and derivative products
  always_comb begin
    s1_next.item      = pop_data;
    s1_next.mag       = pop_data.err[ERR_W-1] ? ERR_W'(-pop_data.err) : ERR_W'(pop_data.err);
    recip_prod        = s1_next.mag * RECIP_500;
    s1_next.quot      = recip_prod[RECIP_SHIFT +: QUOT_W];
    s1_next.prop_prod = $signed({1'b0, cfg.prop_gain}) * pop_data.err;
    s1_next.kd_err    = $signed({1'b0, cfg.deriv_gain}) * pop_data.err;
  end

  // stage 2: remainder test, signed quotient, derivative term times 500
  always_comb begin
    quot_x500          = ((QUOT_W+9)'(s1.quot) << 9) - ((QUOT_W+9)'(s1.quot) << 3)
                       - ((QUOT_W+9)'(s1.quot) << 2);
    kd_ext             = {{9{s1.kd_err[33]}}, s1.kd_err};
    s2_next.item       = s1.item;
    s2_next.t          = s1.item.err[ERR_W-1] ? -$signed({1'b0, s1.quot})
                                              : $signed({1'b0, s1.quot});
    s2_next.rem_pos    = (quot_x500 != (QUOT_W+9)'(s1.mag)) && !s1.item.err[ERR_W-1];
    s2_next.rem_neg    = (quot_x500 != (QUOT_W+9)'(s1.mag)) && s1.item.err[ERR_W-1];
    s2_next.prop_prod  = s1.prop_prod;
    s2_next.deriv_prod = (kd_ext <<< 9) - (kd_ext <<< 3) - (kd_ext <<< 2);
  end

  // stage 3: integral update, truncating toward zero, saturated to 32 bits
  always_comb begin
    i_ext = {{2{integral_sum[31]}}, integral_sum};
    t_ext = {{(34-QUOT_W-1){s2.t[QUOT_W]}}, s2.t};
    j_mid = i_ext + t_ext;
    j_lo  = i_ext + t_ext - 34'sd1;
    j_hi  = i_ext + t_ext + 34'sd1;
    priority if (j_mid > 34'sd0 && s2.rem_neg) begin
      s_raw = j_lo;
    end else if (j_mid < 34'sd0 && s2.rem_pos) begin
      s_raw = j_hi;
    end else begin
      s_raw = j_mid;
    end
    if (s_raw[33:31] != {3{s_raw[31]}}) begin
      s_sat = s_raw[33] ? SUM_MIN : SUM_MAX;
    end else begin
      s_sat = s_raw[31:0];
    end
    s3_next.item = s2.item;
    s3_next.s    = s_sat;
    s3_next.pd   = {{10{s2.prop_prod[33]}}, s2.prop_prod}
                 + {s2.deriv_prod[42], s2.deriv_prod};
  end

  // stage 4: integral product
  always_comb begin
    s4_next.item    = s3.item;
    s4_next.pd      = s3.pd;
    s4_next.ki_prod = $signed({1'b0, cfg.integ_gain}) * s3.s;
  end

  // stage 5: full Q.8 sum
  always_comb begin
    s5_next.item = s4.item;
    s5_next.acc  = {{6{s4.pd[43]}}, s4.pd} + {s4.ki_prod[48], s4.ki_prod};
  end

  // stage 6: scale toward zero, clamp, gate and split into magnitude and direction
  always_comb begin
    u_num   = s5.acc + (s5.acc[49] ? 50'sd255 : 50'sd0);
    u       = u_num[49:8];
    lim_ext = $signed({30'd0, cfg.output_limit});
    priority if (u >= lim_ext) begin
      drive = $signed({1'b0, cfg.output_limit});
    end else if (u <= -lim_ext) begin
      drive = -$signed({1'b0, cfg.output_limit});
    end else begin
      drive = u[LIMIT_W:0];
    end
    if (!(s5.item.active && !s5.item.deadband && s5.item.drive_enable)) begin
      drive = '0;
    end
    out_next.position        = s5.item.position;
    out_next.drive_magnitude = drive[LIMIT_W] ? LIMIT_W'(-drive) : drive[LIMIT_W-1:0];
    out_next.direction       = !drive[LIMIT_W];
    out_next.drive_enable    = s5.item.drive_enable;
    out_next.check_ok        = s5.item.check_ok;
    out_next.fault_count     = s5.item.fault_count;
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1       <= s1_next;
      s2       <= s2_next;
      s3       <= s3_next;
      s4       <= s4_next;
      s5       <= s5_next;
      out_data <= out_next;
    end
  end

  // stage valids and the integral
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      out_valid    <= 1'b0;
      integral_sum <= '0;
    end else if (adv) begin
      s1_valid  <= pop_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
      if (s2_valid && s2.item.active) begin
        integral_sum <= s2.item.deadband ? 32'sd0 : s_sat;
      end
    end
  end

  a_integral_held : assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && !s2.item.active) |=> $stable(integral_sum))
    else $error("integral changed on an inactive tick");

  a_deadband_clears : assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2.item.active && s2.item.deadband) |=> (integral_sum == 32'sd0))
    else $error("integral not cleared inside deadband");

  a_fault_zero_drive : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.drive_enable)
      |-> (out_data.drive_magnitude == '0 && out_data.direction))
    else $error("drive not zero with drive disabled");

endmodule

@@ design/steering_servo_encoder_pid_unit.sv @@
// steering servo controller: check-bit encoder decode followed by a Q8.8 PID
// input channel (in_valid/in_ready/in_data) takes one control tick per beat:
//   encoder response word, setpoint and auto/manual mode
// output channel (out_valid/out_ready/out_data) gives one result per tick:
//   position, drive magnitude and direction, drive enable, check status, fault count
// configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the gains,
//   the output clamp and the fault limit; always ready, write only while idle
// a front stage decodes the word and tracks position and fault count, a two-entry
//   queue decouples it from a six-stage back pipe that runs the integral and gains
// throughput: one tick per cycle when the receiver does not stall, limited by the
//   integral update in back stage 3
// receiver stall: the back pipe holds, the queue fills and in_ready drops
//   once both queue entries are taken; nothing is lost or repeated
// reset: gains 6.0 / 2.0 / 0.0, clamp 3000, fault limit 10, position 4500,
//   integral and fault count cleared, pipe and queue empty
module steering_servo_encoder_pid_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ssep_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ssep_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ssep_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ssep_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ssep_pkg::*;

  cfg_t        cfg;
  logic        push_valid;
  logic        push_ready;
  front_item_t push_data;
  logic        pop_valid;
  logic        pop_ready;
  front_item_t pop_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain    <= PROP_GAIN_RESET;
      cfg.integ_gain   <= INTEG_GAIN_RESET;
      cfg.deriv_gain   <= DERIV_GAIN_RESET;
      cfg.output_limit <= OUTPUT_LIMIT_RESET;
      cfg.fault_limit  <= FAULT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:    cfg.prop_gain    <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:   cfg.integ_gain   <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:   cfg.deriv_gain   <= cfg_data[GAIN_W-1:0];
        CFG_OUTPUT_LIMIT: cfg.output_limit <= cfg_data[LIMIT_W-1:0];
        CFG_FAULT_LIMIT:  cfg.fault_limit  <= cfg_data[FAULT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // decode and classify
  ssep_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .fault_limit (cfg.fault_limit),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // queue between front and back
  ssep_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // controller pipe
  ssep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
